// File: design/trial_division_prime_test_top_defines.svh
// Assertion macros shared by the trial division prime test modules.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Plain property check, clocked on clk_i and disabled while in reset.
`define TRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: whenever ante holds, cons must hold in the same cycle.
`define TRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: whenever ante holds, cons must hold in the next cycle.
`define TRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/trd_pkg.sv
// Package: shared constants, sequencer states and interface structs.
`timescale 1ns / 1ps
package trd_pkg;

  // Default operand width
  localparam int unsigned WIDTH_DEF = 32;

  // Smallest prime and first odd trial divisor
  localparam int unsigned SMALLEST_PRIME    = 2;
  localparam int unsigned FIRST_ODD_DIVISOR = 3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } trd_state_e;

  // Sequencer to remainder unit
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Remainder unit to sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic valid;
    logic is_prime;
  } res_t;

endpackage

// File: design/trd_div.sv
// Shared remainder unit: restoring division, one remainder bit per cycle.
`timescale 1ns / 1ps
`include "trial_division_prime_test_top_defines.svh"
module trd_div
  import trd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctrl_t        ctrl_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output div_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvd_q;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH:0]   trial, diff;
  logic             ge;

  // Single shared subtract and compare
  always_comb begin
    trial = {rem_q, dvd_q[WIDTH-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  end

  // Control: busy for WIDTH steps, then a one-cycle done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: partial remainder and dividend shift line
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

  `TRD_ASSERT_IMP(a_no_restart, ctrl_i.start, !busy_q, "start while division busy")
  `TRD_ASSERT_IMP(a_rem_below_div, done_q, rem_q < div_q, "remainder not below divisor")
  `TRD_ASSERT_NXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")

endmodule

// File: design/trd_seq.sv
// Sequencer: classifies the candidate and steps odd divisors up to the root.
`timescale 1ns / 1ps
`include "trial_division_prime_test_top_defines.svh"
module trd_seq
  import trd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] candidate_i,
  output res_t             res_o,
  input  logic             res_ready_i
);

  // Divisor never exceeds the root by more than one step
  localparam int unsigned DW  = (WIDTH + 1) / 2 + 2;
  // Running square stays below 2^(WIDTH+2) until the loop stops
  localparam int unsigned SQW = WIDTH + 2;

  trd_state_e       state_q, state_d;
  logic [WIDTH-1:0] n_q;
  logic [DW-1:0]    d_q;
  logic [SQW-1:0]   sq_q;
  logic             prime_q;
  logic             small_n, even_n, past_root;
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;

  // Shared remainder unit
  trd_div #(.WIDTH(WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (n_q),
    .divisor_i  (WIDTH'(d_q)),
    .stat_o     (div_stat)
  );

  // Candidate classification and root bound
  always_comb begin
    small_n   = (n_q <= WIDTH'(SMALLEST_PRIME));
    even_n    = !n_q[0];
    past_root = (sq_q > SQW'(n_q));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_CLASSIFY;
      ST_CLASSIFY: state_d = (small_n || even_n) ? ST_FIN : ST_CHECK;
      ST_CHECK:    state_d = past_root ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_d = div_stat.rem_zero ? ST_FIN : ST_CHECK;
      end
      ST_FIN:      if (res_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o     = 1'b0;
    div_ctrl.start = 1'b0;
    res_o.valid    = 1'b0;
    res_o.is_prime = prime_q;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_CHECK: div_ctrl.start = !past_root;
      ST_FIN:   res_o.valid = 1'b1;
      default:  ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Candidate, divisor, running square and verdict
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) n_q <= candidate_i;
      end
      ST_CLASSIFY: begin
        // two is the only even prime, zero and one are not prime
        prime_q <= (n_q == WIDTH'(SMALLEST_PRIME));
        d_q     <= DW'(FIRST_ODD_DIVISOR);
        sq_q    <= SQW'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
      end
      ST_CHECK: begin
        if (past_root) prime_q <= 1'b1;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            prime_q <= 1'b0;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_q  <= d_q + DW'(2);
            sq_q <= sq_q + SQW'({d_q, 2'b00}) + SQW'(4);
          end
        end
      end
      default: ;
    endcase
  end

  `TRD_ASSERT_IMP(a_div_odd,
                  state_q == ST_CHECK || state_q == ST_DIV,
                  d_q[0] && d_q >= DW'(FIRST_ODD_DIVISOR),
                  "trial divisor not odd or below three")
  `TRD_ASSERT_NXT(a_div_hold, state_q == ST_DIV && !div_stat.done,
                  $stable(d_q) && $stable(n_q), "operands moved during division")
  `TRD_ASSERT_IMP(a_prime_odd, res_o.valid && res_o.is_prime,
                  n_q[0] || n_q == WIDTH'(SMALLEST_PRIME),
                  "even candidate other than two reported prime")

endmodule

// File: design/trial_division_prime_test_top.sv
// Top level: trial division prime test with a registered result stage.
`timescale 1ns / 1ps
// Tests one unsigned WIDTH-bit candidate per transfer and returns is_prime_o
// (1 for a prime, 0 for a composite or for zero and one). One candidate is in
// work at a time. Zero, one and even candidates finish after classification. An
// odd candidate n tries the odd divisors from 3 upward while d*d <= n, stopping
// at the first that divides n; each divisor takes WIDTH subtract steps in the
// shared restoring remainder unit, plus the bound check and hand-back.
// The result sits in an output register, so it may wait for the consumer while
// the next candidate is taken in.
module trial_division_prime_test_top
  import trd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] candidate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_prime_o
);

  res_t res;
  logic res_ready;
  logic out_valid_q;
  logic is_prime_q;

  trd_seq #(.WIDTH(WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .candidate_i (candidate_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output stage takes a result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) is_prime_q <= res.is_prime;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

// File: tb/sv/prime_result_checker.sv
// Checker for the prime test: predicts each verdict and compares it with the block.
`timescale 1ns / 1ps
module prime_result_checker
  import trd_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [WIDTH-1:0] candidate_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             is_prime_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);

  // One outstanding verdict, kept with its candidate for reporting
  typedef struct packed {
    logic [WIDTH-1:0] candidate;
    logic             is_prime;
  } verdict_t;

  verdict_t    verdict_q[$];
  int unsigned mismatch_count;

  initial begin
    mismatch_count = 0;
    err_count_o    = 0;
    pending_o      = 0;
  end

  // Trial division over odd divisors up to the exact floor square root
  function automatic logic prime_by_division(input logic [WIDTH-1:0] value);
    longint unsigned n;
    longint unsigned d;
    n = 64'(value);
    if (n < SMALLEST_PRIME) return 1'b0;
    if (n == SMALLEST_PRIME) return 1'b1;
    if ((n & 64'd1) == 64'd0) return 1'b0;
    for (d = FIRST_ODD_DIVISOR; d <= n / d; d += 2) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Only the first few failures are described in full
  task automatic report_failure(input string what);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Watch both channels; results are matched before new candidates are queued
  always @(posedge clk_i) begin
    verdict_t head;
    verdict_t fresh;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_failure($sformatf("result transfer with none expected, is_prime=%0b",
                                   is_prime_i));
        end else begin
          head = verdict_q.pop_front();
          if (is_prime_i !== head.is_prime) begin
            report_failure($sformatf("candidate %0d: is_prime expected %0b, got %0b",
                                     head.candidate, head.is_prime, is_prime_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh.candidate = candidate_i;
        fresh.is_prime  = prime_by_division(candidate_i);
        verdict_q.push_back(fresh);
      end
    end
    err_count_o <= mismatch_count;
    pending_o   <= verdict_q.size();
  end

endmodule

// File: tb/sv/trial_division_prime_test_top_test.sv
// Testbench top: drives candidates into the prime test and gives the verdict.
`timescale 1ns / 1ps
module trial_division_prime_test_top_test;
  import trd_pkg::*;

  localparam int unsigned W            = WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 64;
  localparam int unsigned HOLD_CYCLES  = 1000;
  localparam int unsigned BURST_ITEMS  = 12;
  localparam int unsigned IDLE_PCT     = 14;

  // Extremes, the special cases and exact-square bounds; all stay quick to test
  localparam logic [31:0] DIRECTED [24] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
    32'd97, 32'd121, 32'd169, 32'd65521, 32'd63001, 32'd65535, 32'd65537,
    32'd1018081, 32'd1000003, 32'd16777213, 32'h5555_5555, 32'hFFFF_FFFF,
    32'hFFFF_FFFE, 32'h8000_0000
  };

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic [W-1:0] candidate_i = '0;
  logic         out_ready_i = 1'b0;
  logic         in_ready_o;
  logic         out_valid_o;
  logic         is_prime_o;
  int unsigned  err_count;
  int unsigned  pending;

  // Shared between the sender and the receiver
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  trial_division_prime_test_top #(
    .WIDTH(W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

  prime_result_checker #(
    .WIDTH(W)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_i (is_prime_o),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // Offer one candidate, with an occasional gap first; returns once transferred
  task automatic offer_candidate(input logic [W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    candidate_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Mostly narrow values; wide ones carry a small odd factor or are even, so they finish fast
  function automatic logic [W-1:0] random_candidate();
    int unsigned     pick;
    int unsigned     bits;
    longint unsigned factor;
    longint unsigned value;
    pick = $urandom_range(99);
    if (pick < 45) begin
      bits  = $urandom_range(16, 1);
      value = longint'($urandom) & ((64'd1 << bits) - 64'd1);
    end else if (pick < 60) begin
      bits  = $urandom_range(20, 17);
      value = longint'($urandom) & ((64'd1 << bits) - 64'd1);
    end else if (pick < 85) begin
      factor = 64'(2 * $urandom_range(127, 1) + 1);
      value  = factor * (longint'($urandom) % ((64'd1 << 32) / factor));
    end else begin
      value = longint'($urandom & ~32'd1);
    end
    return W'(value);
  endfunction

  // Receiver: random back-pressure, one long hold-off on request
  initial begin : drain
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (DIRECTED[i]) offer_candidate(W'(DIRECTED[i]));

    // Output held off while small candidates keep coming: the block fills up
    hold_req = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++) offer_candidate(W'($urandom_range(255)));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 30 && i < 60);
      offer_candidate(random_candidate());
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: trial_division_prime_test_top.f
+incdir+design
design/trd_pkg.sv
design/trd_div.sv
design/trd_seq.sv
design/trial_division_prime_test_top.sv
tb/sv/prime_result_checker.sv
tb/sv/trial_division_prime_test_top_test.sv
